// ===== src/dllm_pkg.sv =====
package dllm_pkg;

	localparam int AMOUNT_W   = 40;
	localparam int SUM_W      = 48;
	localparam int COUNT_W    = 32;
	localparam int LIMIT_W    = 40;
	localparam int PCT_W      = 7;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = LIMIT_W;

	localparam int IN_TDATA_W = ((AMOUNT_W + 7) / 8) * 8;

	// loss * 100 fits in SUM_W + 7 bits
	localparam int DIV_N     = SUM_W + 7;
	localparam int DIV_D     = (LIMIT_W > COUNT_W) ? LIMIT_W : COUNT_W;
	localparam int DIV_CNT_W = $clog2(DIV_N);

	localparam int USAGE_W   = 8;
	localparam int USAGE_SAT = 200;
	localparam int USAGE_CAP = 100;

	localparam logic [LIMIT_W-1:0] RST_LOSS_LIMIT = LIMIT_W'(1000000);
	localparam logic [PCT_W-1:0]   RST_WARN_PCT   = PCT_W'(70);
	localparam logic [PCT_W-1:0]   RST_CRIT_PCT   = PCT_W'(90);
	localparam logic               RST_USE_UNRL   = 1'b0;
	localparam logic               RST_KILL_EN    = 1'b1;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic [OP_W-1:0] {
		OP_TRADE  = 2'd0,
		OP_UNREAL = 2'd1,
		OP_RESET  = 2'd2
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOSS_LIMIT = 3'd0,
		REG_WARN_PCT   = 3'd1,
		REG_CRIT_PCT   = 3'd2,
		REG_USE_UNRL   = 3'd3,
		REG_KILL_EN    = 3'd4
	} reg_index_t;

	// last field declared sits in the lowest bits
	typedef struct packed {
		logic [COUNT_W-1:0]         losses_seen;
		logic [COUNT_W-1:0]         wins_seen;
		logic [COUNT_W-1:0]         trades_seen;
		logic [SUM_W-2:0]           worst_drawdown;
		logic signed [AMOUNT_W-1:0] average_result;
		logic signed [SUM_W-1:0]    realized_sum;
		logic [PCT_W-1:0]           usage_pct;
		logic [LIMIT_W-1:0]         limit_left;
		logic signed [SUM_W-1:0]    loss_value;
		logic [2:0]                 fired_events;
		logic [2:0]                 status_flags;
		logic                       accepted;
	} result_t;

	localparam int RES_W       = $bits(result_t);
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

	typedef struct packed {
		logic ld_item;
		logic do_update;
		logic do_peak;
		logic do_loss;
		logic div_start;
		logic do_flags;
		logic ld_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic out_free;
	} ctrl_stat_t;

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] a,
		input logic signed [SUM_W-1:0] b
	);
		logic signed [SUM_W:0] s;
		s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
		if (s[SUM_W] != s[SUM_W-1]) begin
			return s[SUM_W] ? SUM_MIN : SUM_MAX;
		end
		return s[SUM_W-1:0];
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_neg(input logic signed [SUM_W-1:0] v);
		if (v == SUM_MIN) begin
			return SUM_MAX;
		end
		return -v;
	endfunction

endpackage

// ===== src/daily_loss_limit_monitor_top.sv =====
// daily loss limit monitor
// input channel s_axis: tuser carries the opcode (record trade, set unrealized
// value, reset day), tdata the signed amount. one result item per input item
// leaves on m_axis, its tdata packing the flags, loss, usage and statistics.
// config channel cfg: cfg_index selects loss limit, warning percent, critical
// percent, unrealized select or kill enable; cfg_ready is always high. write
// only while no item is in flight.
// each result is valid once its item has passed the update, peak, loss and divider
// start steps, the wait on the two restoring dividers (usage percent and average
// result, 55 quotient bits at one per cycle, run side by side), then the flag
// update and the result load. one item is in work at a time, so the next item is
// taken only after the result of the last one is loaded.
// the result sits in an output register; the next item is accepted while it
// waits. if the receiver stalls longer, the block holds the finished item
// until the output register frees up.
// reset clears all statistics and flags and loads the register defaults
// (limit 1000000, warning 70, critical 90, realized only, kill enabled).
module daily_loss_limit_monitor_top
	import dllm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // amount
	input  logic [OP_W-1:0]        s_axis_tuser,  // opcode
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// accepted, status_flags, fired_events, loss_value, limit_left,
	// usage_pct, realized_sum, average_result, worst_drawdown,
	// trades_seen, wins_seen, losses_seen, zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;
	result_t    res;

	assign cfg_ready = 1'b1;

	dllm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dllm_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_opcode  (s_axis_tuser),
		.in_amount  (s_axis_tdata[AMOUNT_W-1:0]),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (res)
	);

	assign m_axis_tdata = OUT_TDATA_W'(res);

endmodule

// ===== src/dllm_div.sv =====
module dllm_div
	import dllm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_N-1:0] dividend,
	input  logic [DIV_D-1:0] divisor,
	output logic             busy,
	output logic [DIV_N-1:0] quotient
);

	logic [DIV_D:0]     rem_q;
	logic [DIV_N-1:0]   quo_q;
	logic [DIV_D-1:0]   dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic               busy_q;

	logic [DIV_D:0] shifted;
	logic           ge;

	assign shifted = {rem_q[DIV_D-1:0], quo_q[DIV_N-1]};
	assign ge      = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_N - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (shifted - {1'b0, dsr_q}) : shifted;
			quo_q <= {quo_q[DIV_N-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ===== src/dllm_ctrl.sv =====
module dllm_ctrl
	import dllm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_UPDATE  = 8'b0000_0010,
		ST_PEAK    = 8'b0000_0100,
		ST_LOSS    = 8'b0000_1000,
		ST_DIVGO   = 8'b0001_0000,
		ST_DIVWAIT = 8'b0010_0000,
		ST_FLAGS   = 8'b0100_0000,
		ST_FINISH  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.ld_item = 1'b1;
					state_d     = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.do_update = 1'b1;
				state_d       = ST_PEAK;
			end
			ST_PEAK: begin
				cmd.do_peak = 1'b1;
				state_d     = ST_LOSS;
			end
			ST_LOSS: begin
				cmd.do_loss = 1'b1;
				state_d     = ST_DIVGO;
			end
			ST_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVWAIT;
			end
			ST_DIVWAIT: begin
				if (!stat.div_busy) begin
					state_d = ST_FLAGS;
				end
			end
			ST_FLAGS: begin
				cmd.do_flags = 1'b1;
				state_d      = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.ld_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.div_busy)
		else $error("divider started while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_item |=> cmd.do_update)
		else $error("item not followed by update");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |=> in_ready)
		else $error("not idle after result load");

endmodule

// ===== src/dllm_datapath.sv =====
module dllm_datapath
	import dllm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output ctrl_stat_t            stat,
	input  logic [OP_W-1:0]       in_opcode,
	input  logic [AMOUNT_W-1:0]   in_amount,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output result_t               out_result
);

	// configuration
	logic [LIMIT_W-1:0] limit_q;
	logic [PCT_W-1:0]   warn_q;
	logic [PCT_W-1:0]   crit_q;
	logic               unrl_en_q;
	logic               kill_en_q;

	// running state
	logic signed [SUM_W-1:0] realized_q;
	logic signed [SUM_W-1:0] unreal_q;
	logic signed [SUM_W-1:0] peak_q;
	logic [SUM_W-2:0]        drop_q;
	logic [COUNT_W-1:0]      trades_q;
	logic [COUNT_W-1:0]      wins_q;
	logic [COUNT_W-1:0]      losses_q;
	logic [2:0]              flags_q;

	// item in flight
	logic [OP_W-1:0]         op_q;
	logic signed [SUM_W-1:0] amt_q;
	logic                    trade_ok_q;
	logic                    peak_en_q;
	logic [2:0]              fired_q;
	logic signed [SUM_W-1:0] loss_q;
	logic                    out_valid_q;
	result_t                 out_q;

	logic signed [SUM_W-1:0] total;
	logic signed [SUM_W:0]   drop_diff;
	logic [SUM_W-2:0]        drop_new;
	logic                    loss_pos;
	logic [SUM_W-2:0]        loss_mag;
	logic [DIV_N-1:0]        num;
	logic                    avg_neg;
	logic [SUM_W-1:0]        avg_mag;
	logic [DIV_N-1:0]        qu;
	logic [DIV_N-1:0]        qa;
	logic                    busy_u;
	logic                    busy_a;
	logic [USAGE_W-1:0]      usage_raw;
	logic [PCT_W-1:0]        usage_cap;
	logic [DIV_N-1:0]        avg_cap;
	logic [DIV_N-1:0]        avg_clip;
	logic signed [AMOUNT_W-1:0] avg_val;
	logic [SUM_W-1:0]        lim_ext;
	logic [LIMIT_W-1:0]      remaining;
	logic [2:0]              flags_set;

	assign total    = sat_add(realized_q, unreal_q);
	assign loss_pos = !loss_q[SUM_W-1] && (loss_q != '0);
	assign loss_mag = loss_q[SUM_W-2:0];

	// peak and drawdown from the updated total
	always_comb begin
		drop_diff = {peak_q[SUM_W-1], peak_q} - {total[SUM_W-1], total};
		if (total > peak_q) begin
			drop_new = '0;
		end else if (drop_diff[SUM_W-1]) begin
			drop_new = '1;
		end else begin
			drop_new = drop_diff[SUM_W-2:0];
		end
	end

	// loss * 100 as shifts and adds
	assign num = loss_pos ? ((DIV_N'(loss_mag) << 6) + (DIV_N'(loss_mag) << 5)
		+ (DIV_N'(loss_mag) << 2)) : '0;

	assign avg_neg = realized_q[SUM_W-1];
	assign avg_mag = avg_neg ? SUM_W'(-realized_q) : SUM_W'(realized_q);

	dllm_div u_div_usage (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (num),
		.divisor  (DIV_D'(limit_q)),
		.busy     (busy_u),
		.quotient (qu)
	);

	dllm_div u_div_avg (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (DIV_N'(avg_mag)),
		.divisor  (DIV_D'(trades_q)),
		.busy     (busy_a),
		.quotient (qa)
	);

	always_comb begin
		if (!loss_pos) begin
			usage_raw = '0;
		end else if (limit_q == '0) begin
			usage_raw = USAGE_W'(USAGE_SAT);
		end else if (qu > DIV_N'(USAGE_SAT)) begin
			usage_raw = USAGE_W'(USAGE_SAT);
		end else begin
			usage_raw = qu[USAGE_W-1:0];
		end
		usage_cap = (usage_raw > USAGE_W'(USAGE_CAP)) ? PCT_W'(USAGE_CAP)
			: usage_raw[PCT_W-1:0];
	end

	always_comb begin
		flags_set    = '0;
		flags_set[0] = usage_raw >= USAGE_W'(warn_q);
		flags_set[1] = usage_raw >= USAGE_W'(crit_q);
		flags_set[2] = loss_mag >= (SUM_W-1)'(limit_q);
	end

	always_comb begin
		avg_cap  = avg_neg ? (DIV_N'(1) << (AMOUNT_W - 1))
			: ((DIV_N'(1) << (AMOUNT_W - 1)) - DIV_N'(1));
		avg_clip = (qa > avg_cap) ? avg_cap : qa;
		if (trades_q == '0) begin
			avg_val = '0;
		end else if (avg_neg) begin
			avg_val = -avg_clip[AMOUNT_W-1:0];
		end else begin
			avg_val = avg_clip[AMOUNT_W-1:0];
		end
	end

	always_comb begin
		lim_ext = SUM_W'(limit_q);
		if (!loss_pos) begin
			remaining = limit_q;
		end else if (lim_ext > SUM_W'(loss_mag)) begin
			remaining = LIMIT_W'(lim_ext - SUM_W'(loss_mag));
		end else begin
			remaining = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= RST_LOSS_LIMIT;
			warn_q    <= RST_WARN_PCT;
			crit_q    <= RST_CRIT_PCT;
			unrl_en_q <= RST_USE_UNRL;
			kill_en_q <= RST_KILL_EN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOSS_LIMIT: limit_q   <= cfg_data[LIMIT_W-1:0];
				REG_WARN_PCT:   warn_q    <= cfg_data[PCT_W-1:0];
				REG_CRIT_PCT:   crit_q    <= cfg_data[PCT_W-1:0];
				REG_USE_UNRL:   unrl_en_q <= cfg_data[0];
				REG_KILL_EN:    kill_en_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			realized_q <= '0;
			unreal_q   <= '0;
			peak_q     <= '0;
			drop_q     <= '0;
			trades_q   <= '0;
			wins_q     <= '0;
			losses_q   <= '0;
			flags_q    <= '0;
			trade_ok_q <= 1'b0;
			peak_en_q  <= 1'b0;
			fired_q    <= '0;
		end else begin
			if (cmd.do_update) begin
				trade_ok_q <= 1'b0;
				peak_en_q  <= 1'b0;
				fired_q    <= '0;
				unique case (op_q)
					OP_TRADE: begin
						if (!flags_q[2]) begin
							trade_ok_q <= 1'b1;
							peak_en_q  <= 1'b1;
							realized_q <= sat_add(realized_q, amt_q);
							if (trades_q != '1) trades_q <= trades_q + 1'b1;
							if (amt_q > 0 && wins_q != '1) wins_q <= wins_q + 1'b1;
							if (amt_q < 0 && losses_q != '1) losses_q <= losses_q + 1'b1;
						end
					end
					OP_UNREAL: begin
						unreal_q  <= amt_q;
						peak_en_q <= 1'b1;
					end
					OP_RESET: begin
						realized_q <= '0;
						unreal_q   <= '0;
						peak_q     <= '0;
						drop_q     <= '0;
						trades_q   <= '0;
						wins_q     <= '0;
						losses_q   <= '0;
						flags_q    <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.do_peak && peak_en_q) begin
				if (total > peak_q) peak_q <= total;
				if (drop_new > drop_q) drop_q <= drop_new;
			end
			if (cmd.do_flags && trade_ok_q && loss_pos) begin
				flags_q    <= flags_q | flags_set;
				fired_q[0] <= flags_set[0] && !flags_q[0];
				fired_q[1] <= flags_set[1] && !flags_q[1];
				fired_q[2] <= flags_set[2] && !flags_q[2] && kill_en_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			op_q  <= in_opcode;
			amt_q <= SUM_W'($signed(in_amount));
		end
		if (cmd.do_loss) begin
			loss_q <= sat_neg(unrl_en_q ? total : realized_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			out_q.accepted       <= !flags_q[2];
			out_q.status_flags   <= flags_q;
			out_q.fired_events   <= fired_q;
			out_q.loss_value     <= loss_q;
			out_q.limit_left     <= remaining;
			out_q.usage_pct      <= usage_cap;
			out_q.realized_sum   <= realized_q;
			out_q.average_result <= avg_val;
			out_q.worst_drawdown <= drop_q;
			out_q.trades_seen    <= trades_q;
			out_q.wins_seen      <= wins_q;
			out_q.losses_seen    <= losses_q;
		end
	end

	assign stat.div_busy = busy_u || busy_a;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_result    = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(flags_q[2]) |-> $past(cmd.do_update) && $past(op_q) == OP_RESET)
		else $error("limit flag cleared without day reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |=> out_valid_q && out_q.usage_pct <= PCT_W'(USAGE_CAP))
		else $error("bad usage in result");

	assert property (@(posedge clk) disable iff (!arst_n)
		busy_u != busy_a |-> 1'b0)
		else $error("dividers out of step");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |=> out_q.accepted == !out_q.status_flags[2])
		else $error("accepted disagrees with limit flag");

endmodule
